FILE: design/grid_shortest_path_cost_defines.svh
// assertion macros for the grid shortest path block
`ifndef GRID_SHORTEST_PATH_COST_DEFINES_SVH
`define GRID_SHORTEST_PATH_COST_DEFINES_SVH
// implication checked every clock outside reset
`define GSP_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define GSP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

FILE: design/gsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gsp_pkg;
  localparam int GRID_MAX = 128;
  localparam int COST_BITS = 8;
  localparam int HEAP_DEPTH = 65536;
  localparam int COORD_BITS = $clog2(GRID_MAX);
  // cell address: row above column
  localparam int IDX_BITS = 2 * COORD_BITS;
  localparam int CELL_COUNT = 1 << IDX_BITS;
  localparam int SIDE_BITS = $clog2(GRID_MAX + 1);
  localparam int DIST_BITS = 23;
  localparam int PATH_BITS = 22;
  localparam int HADDR_BITS = $clog2(HEAP_DEPTH);
  localparam int HCNT_BITS = HADDR_BITS + 1;
  localparam logic [DIST_BITS-1:0] DIST_INF = '1;
  localparam logic [DIST_BITS-1:0] DIST_SAT = DIST_INF - 1'b1;
  // heap key: distance above cell index, ordered as one number
  localparam int KEY_BITS = DIST_BITS + IDX_BITS;
  typedef logic [KEY_BITS-1:0] key_t;
endpackage
`default_nettype wire

FILE: design/gsp_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gsp_stream_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/grid_shortest_path_cost.sv
`timescale 1ns / 1ps
`default_nettype none
// grid shortest path cost
// cell_in carries one 8-bit cell cost per request, row-major order. When
// grid_size squared cells have arrived the block runs Dijkstra from the
// top-left to the bottom-right cell over four-neighbour moves and offers the
// summed minimum cost (start cell included) on path_out.
// cfg sets grid_size (0 reads as 1, above 128 as 128); a write restarts
// loading. Write it only while idle.
// Cells load at one per cycle while loading; cell_in.ready is low from the
// last cell until the result is registered. The last cell starts a clear of
// the distance memory, then the search: a pop reads the heap top and sifts
// the last entry down, a settled cell skips off-grid neighbours and relaxes
// in-grid ones, a push sifts the new key up, and the final distance is read.
// Reset gives grid_size 128 and an empty block; cell memory is undefined
// until written. The result waits in an output register while path_out is
// stalled; the next grid loads meanwhile, and its search holds its own
// result until the register is free.
module grid_shortest_path_cost (
  input wire logic clk,
  input wire logic rst,
  gsp_stream_if.sink cfg,
  gsp_stream_if.sink cell_in,
  gsp_stream_if.source path_out
);
  localparam int IB = gsp_pkg::IDX_BITS;
  localparam int DB = gsp_pkg::DIST_BITS;
  localparam int HB = gsp_pkg::HADDR_BITS;
  localparam int CB = gsp_pkg::HCNT_BITS;
  localparam int SB = gsp_pkg::SIDE_BITS;
  localparam int RB = gsp_pkg::COORD_BITS;

  typedef enum logic [18:0] {
    S_LOAD   = 19'h00001,
    S_CLEAR  = 19'h00002,
    S_POPRD  = 19'h00004,
    S_POPW   = 19'h00008,
    S_SDN    = 19'h00010,
    S_SDL    = 19'h00020,
    S_SDNW   = 19'h00040,
    S_SDNR   = 19'h00080,
    S_SDNC   = 19'h00100,
    S_CHK    = 19'h00200,
    S_CHKW   = 19'h00400,
    S_NBR    = 19'h00800,
    S_NBRW   = 19'h01000,
    S_NBRC   = 19'h02000,
    S_SUP    = 19'h04000,
    S_SUPC   = 19'h08000,
    S_FIN    = 19'h10000,
    S_FINW   = 19'h20000,
    S_OUT    = 19'h40000
  } state_t;

  // memories
  logic [gsp_pkg::COST_BITS-1:0] cost_mem [gsp_pkg::CELL_COUNT];
  logic [DB-1:0] dist_mem [gsp_pkg::CELL_COUNT];
  gsp_pkg::key_t heap_mem [gsp_pkg::HEAP_DEPTH];

  logic [7:0] grid_size;
  state_t state;
  logic [SB-1:0] side;
  logic [IB:0] total;
  logic [IB:0] load_index;
  logic [RB-1:0] ld_r, ld_c;
  logic [CB-1:0] heap_count;
  logic [CB-1:0] pos;
  logic [CB-1:0] child;
  gsp_pkg::key_t cur_key;
  gsp_pkg::key_t left_key;
  logic [IB-1:0] cur_idx;
  logic [DB-1:0] cur_w;
  logic [RB-1:0] cur_r, cur_c;
  logic [1:0] dir;
  logic [IB-1:0] nb;
  logic [DB-1:0] nd;
  logic [gsp_pkg::PATH_BITS-1:0] result;
  logic out_valid;

  // cost read, distance and heap ports
  logic [gsp_pkg::COST_BITS-1:0] cost_rd;
  logic [DB-1:0] dist_rd;
  gsp_pkg::key_t heap_rd;
  logic cost_we, dist_we, heap_we;
  logic [IB-1:0] cost_addr, dist_addr;
  logic [HB-1:0] heap_addr;
  logic [gsp_pkg::COST_BITS-1:0] cost_wd;
  logic [DB-1:0] dist_wd;
  gsp_pkg::key_t heap_wd;

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_addr] <= cost_wd;
    cost_rd <= cost_mem[cost_addr];
  end
  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_addr] <= dist_wd;
    dist_rd <= dist_mem[dist_addr];
  end
  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_addr] <= heap_wd;
    heap_rd <= heap_mem[heap_addr];
  end

  // clamped side and cell count
  always_comb begin
    if (grid_size == 8'd0) side = SB'(1);
    else if (grid_size > 8'(gsp_pkg::GRID_MAX)) side = SB'(gsp_pkg::GRID_MAX);
    else side = SB'(grid_size);
  end
  assign total = (IB+1)'(side) * (IB+1)'(side);

  // row and column walk for loading and clearing
  logic ld_wrap;
  assign ld_wrap = (SB'(ld_c) + SB'(1) == side);
  logic [RB-1:0] last_rc;
  assign last_rc = RB'(side - SB'(1));

  // neighbour candidate and in-grid test
  logic nb_ok;
  logic [RB:0] nr, nc;
  always_comb begin
    nr = {1'b0, cur_r};
    nc = {1'b0, cur_c};
    nb_ok = 1'b0;
    case (dir)
      2'd0: begin nc = nc + 1'b1; nb_ok = (SB'(nc) < side); end
      2'd1: begin nr = nr + 1'b1; nb_ok = (SB'(nr) < side); end
      2'd2: begin nc = nc - 1'b1; nb_ok = (cur_c != '0); end
      default: begin nr = nr - 1'b1; nb_ok = (cur_r != '0); end
    endcase
  end
  logic [IB-1:0] nb_calc;
  assign nb_calc = {nr[RB-1:0], nc[RB-1:0]};

  // saturating neighbour distance
  logic [DB:0] sum;
  assign sum = {1'b0, cur_w} + (DB+1)'(cost_rd);
  assign nd = (sum > {1'b0, gsp_pkg::DIST_SAT}) ? gsp_pkg::DIST_SAT : sum[DB-1:0];

  // push key and parent index
  gsp_pkg::key_t push_key;
  assign push_key = {nd, nb};
  logic [CB-1:0] parent;
  assign parent = (pos - 1'b1) >> 1;

  // smaller child during sift-down
  gsp_pkg::key_t min_key;
  logic [CB-1:0] min_pos;
  always_comb begin
    if (state == S_SDNR && heap_rd < left_key) begin
      min_key = heap_rd;
      min_pos = child + 1'b1;
    end else if (state == S_SDNR) begin
      min_key = left_key;
      min_pos = child;
    end else begin
      min_key = heap_rd;
      min_pos = child;
    end
  end
  logic sift_more;
  assign sift_more = (min_key < cur_key);
  logic last_child;
  assign last_child = (child + 1'b1 >= heap_count);
  logic seed;
  assign seed = (load_index == '0) && (heap_count == '0);

  assign cfg.ready = (state == S_LOAD);
  assign cell_in.ready = (state == S_LOAD);
  assign path_out.valid = out_valid;
  assign path_out.data = result;

  logic last_cell;
  assign last_cell = (load_index + 1'b1 >= total);

  // memory port drive
  always_comb begin
    cost_we = 1'b0; cost_addr = nb_calc; cost_wd = cell_in.data[gsp_pkg::COST_BITS-1:0];
    dist_we = 1'b0; dist_addr = nb_calc; dist_wd = nd;
    heap_we = 1'b0; heap_addr = HB'(pos); heap_wd = push_key;
    case (state)
      S_LOAD: begin
        cost_addr = {ld_r, ld_c};
        cost_we = cell_in.valid && cell_in.ready;
        dist_addr = '0;
      end
      S_CLEAR: begin
        dist_addr = {ld_r, ld_c};
        dist_we = 1'b1;
        dist_wd = gsp_pkg::DIST_INF;
        cost_addr = '0;
      end
      S_POPRD: begin
        heap_addr = '0;
        // start cell distance is its own cost
        if (seed) begin
          dist_addr = '0;
          dist_we = 1'b1;
          dist_wd = DB'(cost_rd);
        end
      end
      S_POPW: heap_addr = HB'(heap_count);
      S_SDN: heap_addr = HB'(child);
      S_SDL: heap_addr = HB'(child);
      S_SDNW: begin
        if (!last_child) begin
          heap_addr = HB'(child + 1'b1);
        end else begin
          heap_addr = HB'(pos);
          heap_we = sift_more;
          heap_wd = min_key;
        end
      end
      S_SDNR: begin
        heap_addr = HB'(pos);
        heap_we = sift_more;
        heap_wd = min_key;
      end
      S_SDNC: begin
        heap_addr = HB'(pos);
        heap_we = 1'b1;
        heap_wd = cur_key;
      end
      S_CHK: dist_addr = cur_idx;
      S_NBR: begin dist_addr = nb_calc; cost_addr = nb_calc; end
      S_NBRC: begin
        dist_addr = nb;
        dist_we = (dist_rd > nd);
      end
      S_SUP: heap_addr = HB'(parent);
      S_OUT: begin
        heap_addr = HB'(pos);
        heap_we = (heap_rd > cur_key);
        heap_wd = heap_rd;
      end
      S_SUPC: begin
        heap_addr = HB'(pos);
        heap_we = 1'b1;
        heap_wd = cur_key;
      end
      S_FIN: dist_addr = {last_rc, last_rc};
      S_FINW: dist_addr = {last_rc, last_rc};
      default: ;
    endcase
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= 8'd128;
      state <= S_LOAD;
      load_index <= '0;
      ld_r <= '0;
      ld_c <= '0;
      heap_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && path_out.ready) out_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (cfg.valid && cfg.ready) begin
            grid_size <= cfg.data;
            load_index <= '0;
            ld_r <= '0;
            ld_c <= '0;
          end else if (cell_in.valid && cell_in.ready) begin
            if (last_cell) begin
              load_index <= '0;
              ld_r <= '0;
              ld_c <= '0;
              state <= S_CLEAR;
            end else begin
              load_index <= load_index + 1'b1;
              if (ld_wrap) begin
                ld_c <= '0;
                ld_r <= ld_r + 1'b1;
              end else begin
                ld_c <= ld_c + 1'b1;
              end
            end
          end
        end
        S_CLEAR: begin
          if (load_index + 1'b1 >= total) begin
            load_index <= '0;
            ld_r <= '0;
            ld_c <= '0;
            state <= S_POPRD;
            heap_count <= '0;
            cur_key <= '0;
            pos <= '0;
          end else begin
            load_index <= load_index + 1'b1;
            if (ld_wrap) begin
              ld_c <= '0;
              ld_r <= ld_r + 1'b1;
            end else begin
              ld_c <= ld_c + 1'b1;
            end
          end
        end
        S_POPRD: begin
          // first pass settles the start cell without the heap
          if (seed) begin
            load_index <= (IB+1)'(1);
            cur_idx <= '0;
            cur_w <= DB'(cost_rd);
            state <= S_NBR;
            dir <= 2'd0;
            cur_r <= '0; cur_c <= '0;
          end else if (heap_count == '0) begin
            state <= S_FIN;
          end else begin
            heap_count <= heap_count - 1'b1;
            state <= S_POPW;
          end
        end
        S_POPW: begin
          // heap_rd is the top now
          cur_idx <= heap_rd[IB-1:0];
          cur_w <= heap_rd[gsp_pkg::KEY_BITS-1:IB];
          if (heap_count == '0) begin
            state <= S_CHK;
          end else begin
            pos <= '0;
            child <= CB'(1);
            state <= S_SDN;
          end
        end
        S_SDN: begin
          // last entry sifts down from the root
          cur_key <= heap_rd;
          if (child >= heap_count) state <= S_SDNC;
          else state <= S_SDNW;
        end
        S_SDL: begin
          if (child >= heap_count) state <= S_SDNC;
          else state <= S_SDNW;
        end
        S_SDNW: begin
          left_key <= heap_rd;
          if (!last_child) begin
            state <= S_SDNR;
          end else if (sift_more) begin
            pos <= min_pos;
            child <= {min_pos[CB-2:0], 1'b1};
            state <= S_SDL;
          end else begin
            state <= S_SDNC;
          end
        end
        S_SDNR: begin
          if (sift_more) begin
            pos <= min_pos;
            child <= {min_pos[CB-2:0], 1'b1};
            state <= S_SDL;
          end else begin
            state <= S_SDNC;
          end
        end
        S_SDNC: state <= S_CHK;
        S_CHK: state <= S_CHKW;
        S_CHKW: begin
          if (cur_w > dist_rd) state <= S_POPRD;
          else begin
            cur_r <= cur_idx[IB-1:RB];
            cur_c <= cur_idx[RB-1:0];
            dir <= 2'd0;
            state <= S_NBR;
          end
        end
        S_NBR: begin
          nb <= nb_calc;
          if (nb_ok) state <= S_NBRW;
          else if (dir == 2'd3) state <= S_POPRD;
          else dir <= dir + 1'b1;
        end
        S_NBRW: state <= S_NBRC;
        S_NBRC: begin
          if (dist_rd > nd && heap_count < CB'(gsp_pkg::HEAP_DEPTH)) begin
            cur_key <= push_key;
            pos <= heap_count;
            heap_count <= heap_count + 1'b1;
            state <= S_SUP;
          end else if (dir == 2'd3) state <= S_POPRD;
          else begin
            dir <= dir + 1'b1;
            state <= S_NBR;
          end
        end
        S_SUP: begin
          if (pos == '0) state <= S_SUPC;
          else state <= S_OUT;
        end
        S_OUT: begin
          // larger parent moves down into pos
          if (heap_rd <= cur_key) state <= S_SUPC;
          else begin
            pos <= parent;
            state <= S_SUP;
          end
        end
        S_SUPC: begin
          if (dir == 2'd3) state <= S_POPRD;
          else begin
            dir <= dir + 1'b1;
            state <= S_NBR;
          end
        end
        S_FIN: state <= S_FINW;
        S_FINW: begin
          // hold until the output register is free
          if (!out_valid) begin
            result <= dist_rd[gsp_pkg::PATH_BITS-1:0];
            out_valid <= 1'b1;
            load_index <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: design/gsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "grid_shortest_path_cost_defines.svh"
module gsp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic cell_valid,
  input wire logic cell_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [gsp_pkg::PATH_BITS-1:0] out_data
);
  // a waiting result holds its value
  `GSP_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // a result never starts right after a cell request
  `GSP_ASSERT_NEXT(a_gap, clk, rst, cell_valid && cell_ready, !$rose(out_valid))
  // reset leaves no result pending
  `GSP_ASSERT_NEXT(a_rst, clk, 1'b0, rst, !out_valid)
endmodule

bind grid_shortest_path_cost gsp_checker u_chk (
  .clk(clk), .rst(rst),
  .cell_valid(cell_in.valid), .cell_ready(cell_in.ready),
  .out_valid(path_out.valid), .out_ready(path_out.ready),
  .out_data(path_out.data)
);
`default_nettype wire

FILE: bench/tb_grid_shortest_path_cost.sv
`timescale 1ns / 1ps
module tb_grid_shortest_path_cost;
  localparam int STALL_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 500;
  localparam int NOT_TYPED = -1;
  localparam int PB = gsp_pkg::PATH_BITS;

  typedef enum logic {ROW_SIDE, ROW_CELL} row_kind_t;
  typedef struct {
    row_kind_t kind;
    int value;
    int typed_cost;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gsp_stream_if #(8) cfg();
  gsp_stream_if #(8) cell_in();
  gsp_stream_if #(PB) path_out();

  grid_shortest_path_cost dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg.sink),
    .cell_in(cell_in.source),
    .path_out(path_out.source)
  );

  // shadow of the block
  int side_used;
  int cells_loaded;
  int grid_cost [gsp_pkg::CELL_COUNT];
  int best [gsp_pkg::CELL_COUNT];
  bit settled [gsp_pkg::CELL_COUNT];

  logic [PB-1:0] cost_queue [$];
  int fail_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cycles = 0;
  stim_row_t rows [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // minimum path cost over the loaded grid, start cell included
  function automatic int shortest_cost(int n);
    int total, pick, r, c, nr, nc, nb, d;
    int dr [4];
    int dc [4];
    total = n * n;
    dr = '{0, 1, 0, -1};
    dc = '{1, 0, -1, 0};
    for (int i = 0; i < total; i++) begin
      best[i] = 32'h7fffffff;
      settled[i] = 1'b0;
    end
    best[0] = grid_cost[0];
    for (int k = 0; k < total; k++) begin
      pick = -1;
      for (int i = 0; i < total; i++)
        if (!settled[i] && (pick < 0 || best[i] < best[pick])) pick = i;
      settled[pick] = 1'b1;
      r = pick / n;
      c = pick % n;
      for (d = 0; d < 4; d++) begin
        nr = r + dr[d];
        nc = c + dc[d];
        if (nr >= 0 && nc >= 0 && nr < n && nc < n) begin
          nb = nr * n + nc;
          if (best[pick] + grid_cost[nb] < best[nb]) best[nb] = best[pick] + grid_cost[nb];
        end
      end
    end
    return best[total - 1];
  endfunction

  // wait for the block to go quiet, then write grid_size
  task automatic write_side(int value);
    wait (cost_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= value[7:0];
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    side_used = (value[7:0] == 0) ? 1 :
                (value[7:0] > gsp_pkg::GRID_MAX) ? gsp_pkg::GRID_MAX : value[7:0];
    cells_loaded = 0;
  endtask

  // one cell request; typed_cost overrides the predictor when given
  task automatic send_cell(int value, int typed_cost);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      cell_in.valid <= 1'b0;
    end
    @(negedge clk);
    cell_in.valid <= 1'b1;
    cell_in.data <= value[7:0];
    do @(posedge clk); while (!cell_in.ready);
    if (cells_loaded >= side_used * side_used) cells_loaded = 0;
    grid_cost[cells_loaded] = value[7:0];
    cells_loaded++;
    if (cells_loaded == side_used * side_used) begin
      if (typed_cost != NOT_TYPED) cost_queue.push_back(PB'(typed_cost));
      else cost_queue.push_back(PB'(shortest_cost(side_used)));
      cells_loaded = 0;
    end
  endtask

  task automatic idle_cell();
    @(negedge clk);
    cell_in.valid <= 1'b0;
  endtask

  // random cell cost, half wide spread, the rest cheap or wall-like cells
  function automatic int random_cost();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom_range(255);
    if (sel < 8) return $urandom_range(3);
    return $urandom_range(255, 240);
  endfunction

  // result checker
  always @(posedge clk) begin
    logic [PB-1:0] want;
    if (!rst && path_out.valid && path_out.ready) begin
      if (cost_queue.size() == 0) begin
        $error("path_cost result with nothing expected: actual %0d", path_out.data);
        fail_count++;
      end else begin
        want = cost_queue.pop_front();
        if (path_out.data !== want) begin
          $error("path_cost mismatch: expected %0d actual %0d", want, path_out.data);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    path_out.ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (cfg.valid && cfg.ready) || (cell_in.valid && cell_in.ready)
        || (path_out.valid && path_out.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int phase_cells, n, total, cut;
    cfg.valid = 1'b0;
    cfg.data = '0;
    cell_in.valid = 1'b0;
    cell_in.data = '0;
    path_out.ready = 1'b0;
    side_used = gsp_pkg::GRID_MAX;
    cells_loaded = 0;

    // directed rows: extremes, clamping and a write in the middle of a grid
    rows.push_back('{ROW_SIDE, 1, NOT_TYPED});
    rows.push_back('{ROW_CELL, 0, 0});
    rows.push_back('{ROW_CELL, 255, 255});
    rows.push_back('{ROW_SIDE, 0, NOT_TYPED});
    rows.push_back('{ROW_CELL, 170, 170});
    rows.push_back('{ROW_SIDE, 2, NOT_TYPED});
    rows.push_back('{ROW_CELL, 255, NOT_TYPED});
    rows.push_back('{ROW_CELL, 255, NOT_TYPED});
    rows.push_back('{ROW_CELL, 255, NOT_TYPED});
    rows.push_back('{ROW_CELL, 255, 765});
    rows.push_back('{ROW_SIDE, 3, NOT_TYPED});
    rows.push_back('{ROW_CELL, 9, NOT_TYPED});
    rows.push_back('{ROW_CELL, 85, NOT_TYPED});
    rows.push_back('{ROW_SIDE, 200, NOT_TYPED});
    rows.push_back('{ROW_CELL, 1, NOT_TYPED});
    rows.push_back('{ROW_CELL, 2, NOT_TYPED});
    rows.push_back('{ROW_SIDE, 255, NOT_TYPED});
    rows.push_back('{ROW_SIDE, 128, NOT_TYPED});
    rows.push_back('{ROW_SIDE, 2, NOT_TYPED});
    rows.push_back('{ROW_CELL, 0, NOT_TYPED});
    rows.push_back('{ROW_CELL, 255, NOT_TYPED});
    rows.push_back('{ROW_CELL, 255, NOT_TYPED});
    rows.push_back('{ROW_CELL, 0, 255});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first grid at the reset size is partly loaded, then dropped by a write
    send_cell(3, NOT_TYPED);
    send_cell(4, NOT_TYPED);
    idle_cell();

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_SIDE) begin
        idle_cell();
        write_side(rows[i].value);
      end else begin
        send_cell(rows[i].value, rows[i].typed_cost);
      end
    end
    idle_cell();

    // random grids under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 17 : (phase == 1) ? 78 : 0;
      recv_idle = (phase == 0) ? 78 : (phase == 1) ? 17 : 0;
      phase_cells = 0;
      while (phase_cells < 200) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(6, 1);
        if ($urandom_range(19) == 0) n = 0;
        idle_cell();
        write_side(n);
        total = (n == 0) ? 1 : n * n;
        // sometimes break off a grid part way and restart it
        if (total > 1 && $urandom_range(7) == 0) begin
          cut = $urandom_range(total - 1, 1);
          for (int k = 0; k < cut; k++) send_cell(random_cost(), NOT_TYPED);
          phase_cells += cut;
          idle_cell();
          write_side(n);
        end
        for (int k = 0; k < total; k++) send_cell(random_cost(), NOT_TYPED);
        phase_cells += total;
      end
    end
    idle_cell();

    wait (cost_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && cost_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
